FILE: design/sfr_pkg.sv
package sfr_pkg;

    // Text bytes and configuration port.
    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_REG_W   = 4;
    localparam int BYTE_SEL_W  = $clog2(CFG_DATA_W / BYTE_W);

    // Pattern window and line limits.
    localparam int MAX_PATTERN = 8;
    localparam int LINE_LIMIT  = 1024;
    localparam int PAT_LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int LINE_CNT_W  = $clog2(LINE_LIMIT);

    // Replacement string.
    localparam int REPL_MAX    = 8;
    localparam int REPL_IDX_W  = $clog2(REPL_MAX);

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES = 2'd0,
        CFG_PATTERN_LEN   = 2'd1,
        CFG_REPL_BYTES    = 2'd2,
        CFG_REPL_LEN      = 2'd3
    } sfr_cfg_idx_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_IN_LONG  = 2'd1,
        STATUS_OUT_LONG = 2'd2
    } sfr_status_t;

    // Per-cell controls of the pending window.
    typedef struct packed {
        logic load;
        logic shift;
        logic live;
    } sfr_cell_ctrl_t;

endpackage

FILE: design/sfr_in_if.sv
interface sfr_in_if;
    import sfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: design/sfr_out_if.sv
interface sfr_out_if;
    import sfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic [1:0]        status;

    modport source (output valid, output out_byte, output last_of_run, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input status,
                    output ready);
endinterface

FILE: design/sfr_cell.sv
module sfr_cell (
    input  logic                          clk,
    input  sfr_pkg::sfr_cell_ctrl_t       ctrl,
    input  logic [sfr_pkg::BYTE_W-1:0]    load_byte,
    input  logic [sfr_pkg::BYTE_W-1:0]    next_byte,
    input  logic [sfr_pkg::BYTE_W-1:0]    ref_byte,
    input  logic                          chain_in,
    output logic [sfr_pkg::BYTE_W-1:0]    cell_byte,
    output logic                          chain_out
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // A cell loads a new text byte or takes its right neighbor's byte on a shift.
    always_comb
    begin
        priority if (ctrl.load)
        begin
            byte_next = load_byte;
        end
        else if (ctrl.shift)
        begin
            byte_next = next_byte;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // Cells that hold no live byte do not break the prefix chain.
    assign chain_out = chain_in && (!ctrl.live || (byte_reg == ref_byte));
    assign cell_byte = byte_reg;

endmodule

FILE: design/stream_find_replace.sv
// A word waits in the input register until the idle sequencer takes it. Plain copies
// and input error words go from idle to the output register; replacements, window
// drains and flushes come from the REPL, DRAIN and FLUSH states. The sequencer takes a
// new word only once the last one's results are out, paced by the one-word-per-cycle
// output register while the receiver is ready. Reset (rst_n, asynchronous, active low)
// clears control, counters, error and configuration; window cells are not cleared.
module stream_find_replace (
    input  logic                              clk,
    input  logic                              rst_n,
    sfr_in_if.sink                            text_in,
    sfr_out_if.source                         text_out,
    input  logic                              cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sfr_pkg::*;

    // The sequencer works on one held word at a time. Only idle takes a new word from the
    // input register; the other states emit one word per cycle unless the output stalls.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DRAIN = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_REPL  = 4'b1000
    } sfr_state_t;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [LEN_REG_W-1:0]  pattern_len_reg;
    logic [CFG_DATA_W-1:0] repl_bytes_reg;
    logic [LEN_REG_W-1:0]  repl_len_reg;

    // Input holding register, so that a word can be taken while another is at work.
    logic              hold_valid_reg;
    logic              hold_valid_next;
    logic [BYTE_W-1:0] hold_byte_reg;
    logic              hold_take;

    // Sequencer and line state.
    sfr_state_t            state_reg,    state_next;
    logic [PAT_LEN_W-1:0]  pend_cnt_reg, pend_cnt_next;
    logic [LINE_CNT_W-1:0] in_line_reg,  in_line_next;
    logic [LINE_CNT_W-1:0] out_line_reg, out_line_next;
    sfr_status_t           err_reg,      err_next;
    logic [REPL_IDX_W-1:0] repl_idx_reg, repl_idx_next;

    // Output register.
    logic              out_valid_reg,  out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg,   out_byte_next;
    logic              out_last_reg,   out_last_next;
    logic [1:0]        out_status_reg, out_status_next;

    // Derived values.
    logic [PAT_LEN_W-1:0] len_eff;
    logic [LEN_REG_W-1:0] repl_len_eff;
    logic [PAT_LEN_W-1:0] ins_pos;
    logic [PAT_LEN_W-1:0] ins_cnt;
    logic                 ins_hit;
    logic                 ins_go;
    logic                 win_shift;
    logic                 slot_free;
    logic                 start;
    logic                 line_full;
    logic                 emit_req;
    logic [BYTE_W-1:0]    emit_byte;
    logic                 emit_last;
    logic                 emit_eol;
    logic                 emit_ovf;
    logic [BYTE_W-1:0]    repl_byte;
    logic                 repl_last;

    // Window cells.
    sfr_cell_ctrl_t       cell_ctrl [MAX_PATTERN];
    logic [BYTE_W-1:0]    cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] chain;
    logic                 shift_prefix;

    // Lengths beyond what the hardware holds act as the largest one.
    assign len_eff      = (pattern_len_reg > LEN_REG_W'(MAX_PATTERN)) ?
                          PAT_LEN_W'(MAX_PATTERN) : PAT_LEN_W'(pattern_len_reg);
    assign repl_len_eff = (repl_len_reg > LEN_REG_W'(REPL_MAX)) ?
                          LEN_REG_W'(REPL_MAX) : repl_len_reg;

    // The window always holds a prefix of the pattern, so a new word extends the
    // match exactly when it equals the pattern byte at its insert position.
    assign ins_pos = (pend_cnt_reg >= len_eff) ? '0 : pend_cnt_reg;
    assign ins_cnt = ins_pos + PAT_LEN_W'(1);
    assign ins_hit = (hold_byte_reg ==
                      pattern_bytes_reg[{BYTE_SEL_W'(ins_pos), 3'b000} +: BYTE_W]);

    assign repl_byte = repl_bytes_reg[{repl_idx_reg, 3'b000} +: BYTE_W];
    assign repl_last = ({1'b0, repl_idx_reg} == (repl_len_eff - LEN_REG_W'(1)));

    assign slot_free = !out_valid_reg || text_out.ready;
    assign start     = (state_reg == ST_IDLE) && hold_valid_reg && (err_reg == STATUS_OK)
                       && slot_free;
    // After a sticky error the held word is dropped without a result.
    assign hold_take = start ||
                       ((state_reg == ST_IDLE) && hold_valid_reg && (err_reg != STATUS_OK));
    assign line_full = (in_line_reg == LINE_CNT_W'(LINE_LIMIT - 1));
    assign emit_ovf  = (out_line_reg == LINE_CNT_W'(LINE_LIMIT - 1));

    // Row of window cells. Bytes move toward cell 0 on a shift; the prefix chain
    // runs from the far end and tells whether the window, once shifted, still
    // matches the start of the pattern.
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        localparam int RefIdx = (i == 0) ? 0 : i - 1;

        assign cell_ctrl[i].load  = ins_go && (ins_pos == PAT_LEN_W'(i));
        assign cell_ctrl[i].shift = win_shift;
        assign cell_ctrl[i].live  = (i != 0) && (PAT_LEN_W'(i) < pend_cnt_reg);

        sfr_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .load_byte (hold_byte_reg),
            .next_byte ((i == MAX_PATTERN - 1) ? {BYTE_W{1'b0}} :
                        cell_byte[(i == MAX_PATTERN - 1) ? i : i + 1]),
            .ref_byte  (pattern_bytes_reg[BYTE_W*RefIdx +: BYTE_W]),
            .chain_in  ((i == MAX_PATTERN - 1) ? 1'b1 :
                        chain[(i == MAX_PATTERN - 1) ? i : i + 1]),
            .cell_byte (cell_byte[i]),
            .chain_out (chain[i])
        );
    end

    assign shift_prefix = chain[0];

    // Main sequencer.
    always_comb
    begin
        state_next      = state_reg;
        pend_cnt_next   = pend_cnt_reg;
        in_line_next    = in_line_reg;
        out_line_next   = out_line_reg;
        err_next        = err_reg;
        repl_idx_next   = repl_idx_reg;
        out_valid_next  = out_valid_reg && !text_out.ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        ins_go          = 1'b0;
        win_shift       = 1'b0;
        emit_req        = 1'b0;
        emit_byte       = '0;
        emit_last       = 1'b0;
        emit_eol        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    priority if (line_full)
                    begin
                        // Input line too long: one error word, then silence.
                        out_valid_next  = 1'b1;
                        out_byte_next   = '0;
                        out_last_next   = 1'b1;
                        out_status_next = STATUS_IN_LONG;
                        err_next        = STATUS_IN_LONG;
                    end
                    else if (hold_byte_reg == NEWLINE)
                    begin
                        in_line_next = '0;
                        state_next   = ST_FLUSH;
                    end
                    else
                    begin
                        in_line_next = in_line_reg + LINE_CNT_W'(1);
                        priority if (len_eff == '0)
                        begin
                            emit_req  = 1'b1;
                            emit_byte = hold_byte_reg;
                            emit_last = 1'b1;
                        end
                        else
                        begin
                            ins_go = 1'b1;
                            priority if (ins_hit && (ins_cnt == len_eff))
                            begin
                                pend_cnt_next = '0;
                                repl_idx_next = '0;
                                if (repl_len_eff != '0)
                                begin
                                    state_next = ST_REPL;
                                end
                            end
                            else if (ins_hit)
                            begin
                                pend_cnt_next = ins_cnt;
                            end
                            else
                            begin
                                pend_cnt_next = ins_cnt;
                                state_next    = ST_DRAIN;
                            end
                        end
                    end
                end
            end

            ST_DRAIN:
            begin
                // Give up the oldest byte until the rest is a pattern prefix again.
                if (slot_free)
                begin
                    emit_req      = 1'b1;
                    emit_byte     = cell_byte[0];
                    emit_last     = (pend_cnt_reg == PAT_LEN_W'(1)) || shift_prefix;
                    win_shift     = 1'b1;
                    pend_cnt_next = pend_cnt_reg - PAT_LEN_W'(1);
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_FLUSH:
            begin
                // Pending bytes go out in order, then the newline closes the line.
                if (slot_free)
                begin
                    emit_req = 1'b1;
                    if (pend_cnt_reg == '0)
                    begin
                        emit_byte  = NEWLINE;
                        emit_last  = 1'b1;
                        emit_eol   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_byte     = cell_byte[0];
                        win_shift     = 1'b1;
                        pend_cnt_next = pend_cnt_reg - PAT_LEN_W'(1);
                    end
                end
            end

            ST_REPL:
            begin
                if (slot_free)
                begin
                    emit_req      = 1'b1;
                    emit_byte     = repl_byte;
                    emit_last     = repl_last;
                    repl_idx_next = repl_idx_reg + REPL_IDX_W'(1);
                    if (repl_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Every text word passes the output line check. A word that would overflow
        // the line becomes the error word and ends all output.
        if (emit_req)
        begin
            out_valid_next = 1'b1;
            if (emit_ovf)
            begin
                out_byte_next   = '0;
                out_last_next   = 1'b1;
                out_status_next = STATUS_OUT_LONG;
                err_next        = STATUS_OUT_LONG;
                state_next      = ST_IDLE;
            end
            else
            begin
                out_byte_next   = emit_byte;
                out_last_next   = emit_last;
                out_status_next = STATUS_OK;
                out_line_next   = emit_eol ? '0 : out_line_reg + LINE_CNT_W'(1);
            end
        end

        // A new pattern invalidates whatever the window holds.
        if (cfg_we && ((cfg_index == CFG_PATTERN_BYTES) || (cfg_index == CFG_PATTERN_LEN)))
        begin
            pend_cnt_next = '0;
        end
    end

    // Input holding register.
    assign text_in.ready = !hold_valid_reg || hold_take;

    always_comb
    begin
        priority if (text_in.valid && text_in.ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (hold_take)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            hold_byte_reg <= text_in.in_byte;
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg    <= 1'b0;
            state_reg         <= ST_IDLE;
            pend_cnt_reg      <= '0;
            in_line_reg       <= '0;
            out_line_reg      <= '0;
            err_reg           <= STATUS_OK;
            repl_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
            pattern_bytes_reg <= '0;
            pattern_len_reg   <= '0;
            repl_bytes_reg    <= '0;
            repl_len_reg      <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            state_reg      <= state_next;
            pend_cnt_reg   <= pend_cnt_next;
            in_line_reg    <= in_line_next;
            out_line_reg   <= out_line_next;
            err_reg        <= err_next;
            repl_idx_reg   <= repl_idx_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PATTERN_BYTES: pattern_bytes_reg <= cfg_data;
                    CFG_PATTERN_LEN:   pattern_len_reg   <= cfg_data[LEN_REG_W-1:0];
                    CFG_REPL_BYTES:    repl_bytes_reg    <= cfg_data;
                    CFG_REPL_LEN:      repl_len_reg      <= cfg_data[LEN_REG_W-1:0];
                    default:           pattern_len_reg   <= pattern_len_reg;
                endcase
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign text_out.valid       = out_valid_reg;
    assign text_out.out_byte    = out_byte_reg;
    assign text_out.last_of_run = out_last_reg;
    assign text_out.status      = out_status_reg;

`ifndef NO_ASSERTIONS
    // An error word always closes the run of results of its input word.
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STATUS_OK)) |-> out_last_reg)
        else $error("error word without last_of_run");

    // Once an error is latched, no new word enters the output register.
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        ((err_reg != STATUS_OK) && !out_valid_reg) |=> !out_valid_reg)
        else $error("output after sticky error");

    // Between words the window is shorter than the pattern.
    a_window_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((pend_cnt_reg == '0) || (pend_cnt_reg < len_eff)))
        else $error("pending window not shorter than pattern");

    // A held word is neither lost nor overwritten before the sequencer takes it.
    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !hold_take) |=> (hold_valid_reg && $stable(hold_byte_reg)))
        else $error("held input word lost");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import sfr_pkg::*;

    // Generous bound on the whole run. The slowest legal run is under sixteen
    // hundred words, each expanding to at most eight output words behind random
    // receiver stalls. That comes to well under this figure.
    localparam int CYCLE_LIMIT   = 400000;
    // Quiet cycles allowed after the last expected word before the block
    // counts as idle. One word can keep the block busy, and a word that
    // yields nothing still sits in the input register.
    localparam int SETTLE_CYCLES = 24;
    // Printing stops here so that a badly broken block cannot flood the log.
    // Counting continues past this point.
    localparam int PRINT_LIMIT   = 60;

    // One word on the output channel.
    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        sfr_status_t       status;
    } text_word_t;

    // One entry of the send queue. A drain entry sends nothing. It holds the
    // sender back until every expected output word has arrived.
    typedef struct {
        logic [BYTE_W-1:0] text;
        bit                drain;
    } send_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sfr_in_if  text_in_ch ();
    sfr_out_if text_out_ch ();

    stream_find_replace u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in_ch),
        .text_out  (text_out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The stimulus fills this queue. The driver drains it one word at a time.
    send_item_t text_to_send[$];
    // Output words predicted from accepted input words, oldest first.
    text_word_t out_words_due[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_gap;
    int recv_gap;
    bit no_idle;

    // Private copy of the configuration registers and of the block state.
    // The find-replace predictor below works from these copies.
    logic [CFG_DATA_W-1:0] match_pat;
    logic [LEN_REG_W-1:0]  match_len;
    logic [CFG_DATA_W-1:0] subst_bytes;
    logic [LEN_REG_W-1:0]  subst_len;
    logic [BYTE_W-1:0]     held [MAX_PATTERN];
    int                    held_count;
    int                    in_col;
    int                    out_col;
    sfr_status_t           sticky_status;
    int                    step_words;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard. A hang anywhere ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL stream_find_replace");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Find-replace predictor
    // ------------------------------------------------------------------

    function automatic void note_word(input logic [BYTE_W-1:0] b, input sfr_status_t st);
        text_word_t w;
        w.out_byte    = b;
        w.last_of_run = 1'b0;
        w.status      = st;
        out_words_due.push_back(w);
        step_words++;
    endfunction

    // Emits one byte onto the current output line. The byte that would make
    // the line LINE_LIMIT long is replaced by an overflow word, and the block
    // then falls silent for good.
    function automatic void emit_text(input logic [BYTE_W-1:0] b);
        if (sticky_status != STATUS_OK)
            return;
        if (out_col >= LINE_LIMIT - 1) begin
            note_word('0, STATUS_OUT_LONG);
            sticky_status = STATUS_OUT_LONG;
        end
        else begin
            note_word(b, STATUS_OK);
            out_col++;
        end
    endfunction

    function automatic bit held_is_prefix(input int n);
        for (int i = 0; i < n && i < MAX_PATTERN; i++)
            if (held[i] != match_pat[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // A byte that is not a newline. With pattern length zero it is copied out.
    // Otherwise it either completes the pattern, which emits the replacement,
    // or extends the held window. In the second case the head of the window is
    // released until what remains is still a prefix of the pattern.
    function automatic void take_text_byte(input logic [BYTE_W-1:0] b);
        int plen;
        int rlen;
        plen = (match_len > MAX_PATTERN) ? MAX_PATTERN : int'(match_len);
        if (plen == 0) begin
            emit_text(b);
            return;
        end
        if (held_count >= plen)
            held_count = 0;
        held[held_count] = b;
        held_count++;
        if (held_count == plen && held_is_prefix(plen)) begin
            rlen = (subst_len > REPL_MAX) ? REPL_MAX : int'(subst_len);
            for (int i = 0; i < rlen; i++)
                emit_text(subst_bytes[8*i +: 8]);
            held_count = 0;
            return;
        end
        while (held_count > 0 && !held_is_prefix(held_count)) begin
            emit_text(held[0]);
            for (int i = 0; i < held_count - 1; i++)
                held[i] = held[i+1];
            held_count--;
        end
    endfunction

    // Works out every output word caused by one accepted input word.
    function automatic void find_replace_step(input logic [BYTE_W-1:0] b);
        text_word_t w;
        step_words = 0;
        if (sticky_status != STATUS_OK)
            return;
        if (in_col + 1 >= LINE_LIMIT) begin
            // This byte would be byte LINE_LIMIT of the input line.
            note_word('0, STATUS_IN_LONG);
            sticky_status = STATUS_IN_LONG;
        end
        else if (b == NEWLINE) begin
            // A newline never matches. It flushes the window and ends the line.
            for (int i = 0; i < held_count && i < MAX_PATTERN; i++)
                emit_text(held[i]);
            emit_text(NEWLINE);
            held_count = 0;
            in_col     = 0;
            out_col    = 0;
        end
        else begin
            in_col++;
            take_text_byte(b);
        end
        if (step_words > 0) begin
            w = out_words_due.pop_back();
            w.last_of_run = 1'b1;
            out_words_due.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued words on the input channel. It inserts random
    // idle bursts and obeys drain entries.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n) begin : drive_text
        send_item_t item;
        logic       next_valid;
        if (!rst_n) begin
            text_in_ch.valid   <= 1'b0;
            text_in_ch.in_byte <= '0;
            send_gap           <= 0;
        end
        else begin
            next_valid = text_in_ch.valid;
            // The slot is free when nothing was offered or the offer was just taken.
            if (!text_in_ch.valid || text_in_ch.ready) begin
                next_valid = 1'b0;
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                end
                else if (text_to_send.size() != 0) begin
                    if (text_to_send[0].drain) begin
                        // The channel must already be quiet, with no word on offer.
                        // That way the last accepted word has been predicted.
                        if (!text_in_ch.valid && out_words_due.size() == 0)
                            void'(text_to_send.pop_front());
                    end
                    else begin
                        item = text_to_send.pop_front();
                        next_valid = 1'b1;
                        text_in_ch.in_byte <= item.text;
                        if (!no_idle && $urandom_range(0, 7) == 0)
                            send_gap <= $urandom_range(1, 9);
                    end
                end
            end
            text_in_ch.valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted input word and checks every
    // accepted output word against the oldest prediction. It also drives the
    // output ready with random stall bursts. Prediction and checking share
    // this one process, so the two never race.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n) begin : watch_text
        text_word_t want;
        if (!rst_n) begin
            text_out_ch.ready <= 1'b0;
            recv_gap          <= 0;
        end
        else begin
            if (text_in_ch.valid && text_in_ch.ready)
                find_replace_step(text_in_ch.in_byte);

            if (text_out_ch.valid && text_out_ch.ready) begin
                if (out_words_due.size() == 0) begin
                    report_mismatch($sformatf("word %02h last %0b status %0d with nothing due",
                        text_out_ch.out_byte, text_out_ch.last_of_run, text_out_ch.status));
                end
                else begin
                    want = out_words_due.pop_front();
                    if (text_out_ch.out_byte !== want.out_byte ||
                        text_out_ch.last_of_run !== want.last_of_run ||
                        text_out_ch.status !== want.status)
                        report_mismatch($sformatf(
                            "got byte %02h last %0b status %0d, want byte %02h last %0b status %0d",
                            text_out_ch.out_byte, text_out_ch.last_of_run, text_out_ch.status,
                            want.out_byte, want.last_of_run, want.status));
                end
            end

            if (recv_gap != 0) begin
                recv_gap          <= recv_gap - 1;
                text_out_ch.ready <= 1'b0;
            end
            else begin
                text_out_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    recv_gap <= $urandom_range(1, 9);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Register write on the configuration port. The local copy is updated
    // along with it. A write to either pattern register drops the held window.
    task automatic write_reg(input sfr_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PATTERN_BYTES: begin
                match_pat  = data;
                held_count = 0;
            end
            CFG_PATTERN_LEN: begin
                match_len  = data[LEN_REG_W-1:0];
                held_count = 0;
            end
            CFG_REPL_BYTES: subst_bytes = data;
            CFG_REPL_LEN:   subst_len   = data[LEN_REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        send_item_t item;
        item.text  = b;
        item.drain = 1'b0;
        text_to_send.push_back(item);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    task automatic queue_pause();
        send_item_t item;
        item.text  = '0;
        item.drain = 1'b1;
        text_to_send.push_back(item);
    endtask

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == NEWLINE)
            b = 8'h0B;
        return b;
    endfunction

    // Returns once everything queued has been sent and every predicted word
    // has arrived. The checks are made at the falling edge, when the driver
    // and the monitor have finished their work for the cycle. The settle
    // period that follows lets a word with no output leave the pipeline
    // before any register changes.
    task automatic wait_drained();
        @(negedge clk);
        while (text_to_send.size() != 0 || text_in_ch.valid || out_words_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random configuration. The pattern is drawn mostly from a three-letter
    // alphabet so that random text matches often. Once in a while a pattern
    // byte is arbitrary, which may include a newline. Lengths above the
    // limits appear now and then.
    task automatic random_config();
        logic [CFG_DATA_W-1:0] pat;
        int                    pick;
        int                    plen;
        int                    rlen;
        for (int i = 0; i < MAX_PATTERN; i++)
            pat[8*i +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'("a" + $urandom_range(0, 2));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            plen = 0;
        else if (pick <= 6)
            plen = $urandom_range(1, 4);
        else if (pick <= 8)
            plen = $urandom_range(5, 8);
        else
            plen = $urandom_range(9, 15);
        rlen = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_PATTERN_LEN, CFG_DATA_W'(plen));
        write_reg(CFG_REPL_BYTES, {$urandom, $urandom});
        write_reg(CFG_REPL_LEN, CFG_DATA_W'(rlen));
    endtask

    // Builds short lines, each ended by a newline. Most chunks are the whole
    // pattern or a broken prefix of it. The rest are letters from the pattern
    // alphabet and arbitrary bytes. Lines stay far below the length limits.
    task automatic queue_random_lines(input int words);
        int count;
        int line_len;
        int line_words;
        int pick;
        int plen;
        int m;
        count = 0;
        plen  = (match_len > MAX_PATTERN) ? MAX_PATTERN : int'(match_len);
        while (count < words) begin
            line_len   = $urandom_range(0, 30);
            line_words = 0;
            while (line_words < line_len) begin
                pick = $urandom_range(0, 9);
                if (pick <= 3 && plen > 0) begin
                    for (int i = 0; i < plen; i++)
                        queue_byte(match_pat[8*i +: 8]);
                    line_words += plen;
                end
                else if (pick <= 5 && plen > 1) begin
                    m = $urandom_range(1, plen - 1);
                    for (int i = 0; i < m; i++)
                        queue_byte(match_pat[8*i +: 8]);
                    line_words += m;
                end
                else if (pick <= 7) begin
                    queue_byte(8'("a" + $urandom_range(0, 2)));
                    line_words++;
                end
                else begin
                    queue_byte(8'($urandom_range(0, 255)));
                    line_words++;
                end
            end
            queue_byte(NEWLINE);
            count += line_words + 1;
            if ($urandom_range(0, 4) == 0)
                queue_pause();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] v;

        // The configuration inputs have a known value from time zero.
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_PATTERN_BYTES;
        cfg_data           = '0;
        no_idle            = 1'b0;

        match_pat     = '0;
        match_len     = '0;
        subst_bytes   = '0;
        subst_len     = '0;
        held_count    = 0;
        in_col        = 0;
        out_col       = 0;
        sticky_status = STATUS_OK;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The reset configuration has pattern length zero, so the block makes
        // a plain copy. The smallest and largest byte values are sent.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(NEWLINE);
        wait_drained();

        // Pattern "ab" becomes "XYZ". In "aab" the first 'a' falls out of the
        // window when the second one arrives. The sender then pauses until the
        // replacement has fully arrived. At the end a held 'a' is flushed by
        // the newline.
        write_reg(CFG_PATTERN_BYTES, 64'h6261);
        write_reg(CFG_PATTERN_LEN, 64'd2);
        write_reg(CFG_REPL_BYTES, 64'h5A5958);
        write_reg(CFG_REPL_LEN, 64'd3);
        queue_text("aab");
        queue_pause();
        queue_text("xa\n");

        // An 'a' is left in the window. Rewriting the pattern drops it, so
        // the 'b' that follows is plain text and not the end of a match.
        queue_text("a");
        wait_drained();
        write_reg(CFG_PATTERN_BYTES, 64'h6261);
        queue_text("b\n");
        wait_drained();

        // Oversized lengths: both length registers at their top value act as
        // eight. An all-ones pattern is replaced by eight zero bytes.
        write_reg(CFG_PATTERN_BYTES, '1);
        write_reg(CFG_PATTERN_LEN, 64'd15);
        write_reg(CFG_REPL_BYTES, '0);
        write_reg(CFG_REPL_LEN, 64'd15);
        repeat (8) queue_byte(8'hFF);
        queue_byte(NEWLINE);
        wait_drained();

        // A pattern that contains a newline can never match. The replacement
        // is empty, so a match would delete text.
        write_reg(CFG_PATTERN_BYTES, 64'h620A61);
        write_reg(CFG_PATTERN_LEN, 64'd3);
        write_reg(CFG_REPL_LEN, 64'd0);
        queue_text("a\nb\n");
        wait_drained();

        // Random phases, each under a new configuration.
        for (int phase = 0; phase < 6; phase++) begin
            random_config();
            queue_random_lines(42);
            wait_drained();
        end

        // Final phase: no idling on either side. The line limit is driven
        // into its sticky error. One of the two kinds is picked at random,
        // since only a reset clears the error. A short tail follows the error
        // and must produce nothing.
        no_idle = 1'b1;
        if ($urandom_range(0, 1) == 0) begin
            // Each 'z' expands to eight words, so the output line overflows
            // long before the input line does.
            v = {$urandom, $urandom};
            v[7:0] = 8'h7A;
            write_reg(CFG_PATTERN_BYTES, v);
            write_reg(CFG_PATTERN_LEN, 64'd1);
            write_reg(CFG_REPL_BYTES, {$urandom, $urandom});
            write_reg(CFG_REPL_LEN, 64'd8);
            repeat (130) queue_byte(8'h7A);
        end
        else begin
            // Plain copy of a line with no newline. The byte after the first
            // LINE_LIMIT-1 bytes, whatever its value, hits the input limit.
            write_reg(CFG_PATTERN_LEN, 64'd0);
            repeat (LINE_LIMIT - 1) queue_byte(plain_byte());
            queue_byte(8'($urandom_range(0, 255)));
        end
        queue_text("tail\n");
        wait_drained();

        if (mismatch_count == 0 && out_words_due.size() == 0)
            $display("PASS stream_find_replace");
        else
            $display("FAIL stream_find_replace");
        $finish;
    end

endmodule

FILE: files.f
design/sfr_pkg.sv
design/sfr_in_if.sv
design/sfr_out_if.sv
design/sfr_cell.sv
design/stream_find_replace.sv
tb/sv/tb.sv
